// File: rtl/lsbse_pkg.sv
package lsbse_pkg;

  // Default sizes of the message length register and the bit queue.
  localparam int LENGTH_BITS_DEF = 16;
  localparam int BUFFER_BITS_DEF = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NB_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BITS_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN    = 3'd4;

  localparam logic [NB_W-1:0] BITS_RESET = 4'd2;
  localparam logic [NB_W-1:0] BITS_MAX   = 4'd8;

  localparam logic MODE_EXTRACT = 1'b0;
  localparam logic MODE_EMBED   = 1'b1;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // One input word as held in the input register.
  typedef struct packed {
    logic       action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] message_byte;
  } item_t;

  // Up to three result words produced by one input word.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            kind;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [2:0][7:0] bytes;
    logic            last;
    logic            under;
    logic            ovf;
  } grp_t;

endpackage

// File: rtl/lsbse_ifs.sv
interface lsbse_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] message_byte;

  modport source (output valid, action, red, green, blue, message_byte, input ready);
  modport sink   (input valid, action, red, green, blue, message_byte, output ready);
endinterface

interface lsbse_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] recovered_byte;
  logic       last_byte;
  logic       underflow;
  logic       overflow;

  modport source (output valid, kind, out_red, out_green, out_blue, recovered_byte,
                  last_byte, underflow, overflow, input ready);
  modport sink   (input valid, kind, out_red, out_green, out_blue, recovered_byte,
                  last_byte, underflow, overflow, output ready);
endinterface

// File: rtl/lsbse_core.sv
module lsbse_core
  import lsbse_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int BUFFER_BITS = BUFFER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  input  item_t                 item,
  output grp_t                  grp_nxt
);

  localparam int ML   = (LENGTH_BITS < CFG_DATA_W) ? LENGTH_BITS : CFG_DATA_W;
  localparam int BL_W = ML + 3;
  localparam int BC_W = $clog2(BUFFER_BITS + 1);
  localparam int EXT  = BUFFER_BITS + 24;

  // Configuration registers.
  logic [NB_W-1:0] bits_red_r, bits_green_r, bits_blue_r;
  logic            mode_r;
  logic [ML-1:0]   msg_len_r;

  // Message state.
  logic [BUFFER_BITS-1:0] buf_r, buf_nxt;
  logic [BC_W-1:0]        bc_r, bc_nxt;
  logic [ML-1:0]          bh_r, bh_nxt;
  logic [BL_W-1:0]        bl_r, bl_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [NB_W-1:0] n0, n1, n2, k0, k1, k2;
  logic [BL_W-1:0] bl1, bl2, bl3;
  logic [4:0]      t;
  logic            active;

  // Embed path.
  logic [EXT-1:0]  ext_sh;
  logic [23:0]     win, w1, w2;
  logic [7:0]      seg0, seg1, seg2;
  logic [7:0]      lm0, lm1, lm2;
  logic [7:0]      f0, f1, f2;
  logic            under;
  logic [BC_W-1:0] bc_take;
  logic [BC_W:0]   bc_push;

  // Extract path.
  logic [7:0]      v0, v1, v2;
  logic [31:0]     acc0, acc1, acc2, acc3, aligned;
  logic [BC_W-1:0] tt;
  logic [4:0]      t5;
  logic [2:0]      rem;

  logic            restart;
  logic [ML-1:0]   len_new;
  logic [NB_W-1:0] v4;

  // Bits each channel carries, limited by what remains of the message.
  always_comb begin
    n0 = bits_red_r;
    n1 = bits_green_r;
    n2 = bits_blue_r;
    k0 = (bl_r < BL_W'(n0)) ? bl_r[NB_W-1:0] : n0;
    bl1 = bl_r - BL_W'(k0);
    k1 = (bl1 < BL_W'(n1)) ? bl1[NB_W-1:0] : n1;
    bl2 = bl1 - BL_W'(k1);
    k2 = (bl2 < BL_W'(n2)) ? bl2[NB_W-1:0] : n2;
    bl3 = bl2 - BL_W'(k2);
    t = 5'(k0) + 5'(k1) + 5'(k2);
    active = (bl_r != '0);
    lm0 = ~(8'hFF << n0);
    lm1 = ~(8'hFF << n1);
    lm2 = ~(8'hFF << n2);
  end

  // Embed: the next 24 queue bits, oldest first, zero filled past the queue.
  always_comb begin
    ext_sh = {buf_r, 24'b0} >> bc_r;
    win = ext_sh[23:0];
    w1 = win << k0;
    w2 = w1 << k1;
    seg0 = win[23:16];
    seg1 = w1[23:16];
    seg2 = w2[23:16];
    f0 = (seg0 & ~(8'hFF >> k0)) >> (4'd8 - n0);
    f1 = (seg1 & ~(8'hFF >> k1)) >> (4'd8 - n1);
    f2 = (seg2 & ~(8'hFF >> k2)) >> (4'd8 - n2);
    under = BC_W'(t) > bc_r;
    bc_take = under ? '0 : bc_r - BC_W'(t);
    bc_push = {1'b0, bc_r} + (BC_W+1)'(8);
  end

  // Extract: append the carried bits of each channel to the pending bits.
  always_comb begin
    v0 = (item.red & lm0) >> (n0 - k0);
    v1 = (item.green & lm1) >> (n1 - k1);
    v2 = (item.blue & lm2) >> (n2 - k2);
    acc0 = {24'b0, buf_r[7:0]};
    acc1 = (acc0 << k0) | {24'b0, v0};
    acc2 = (acc1 << k1) | {24'b0, v1};
    acc3 = (acc2 << k2) | {24'b0, v2};
    tt = bc_r + BC_W'(t);
    t5 = tt[4:0];
    rem = t5[2:0];
    aligned = acc3 << (6'd32 - {1'b0, t5});
  end

  // Next state and the result group.
  always_comb begin
    buf_nxt = buf_r;
    bc_nxt  = bc_r;
    bh_nxt  = bh_r;
    bl_nxt  = bl_r;
    ovf_nxt = ovf_r;
    grp_nxt = '0;
    grp_nxt.ovf = ovf_r;
    if (item.action == ACT_PUSH) begin
      if (mode_r == MODE_EMBED && bh_r < msg_len_r) begin
        if (bc_push <= (BC_W+1)'(BUFFER_BITS)) begin
          buf_nxt = {buf_r[BUFFER_BITS-9:0], item.message_byte};
          bc_nxt  = bc_push[BC_W-1:0];
          bh_nxt  = bh_r + ML'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end else if (mode_r == MODE_EMBED) begin
      grp_nxt.cnt   = 2'd1;
      grp_nxt.kind  = KIND_PIXEL;
      grp_nxt.red   = item.red;
      grp_nxt.green = item.green;
      grp_nxt.blue  = item.blue;
      if (active) begin
        grp_nxt.red   = (item.red & ~lm0) | f0;
        grp_nxt.green = (item.green & ~lm1) | f1;
        grp_nxt.blue  = (item.blue & ~lm2) | f2;
        grp_nxt.under = under;
        bc_nxt  = bc_take;
        buf_nxt = buf_r & ~({BUFFER_BITS{1'b1}} << bc_take);
        bl_nxt  = bl3;
      end
    end else if (active) begin
      grp_nxt.cnt      = t5[4:3];
      grp_nxt.kind     = KIND_BYTE;
      grp_nxt.bytes[0] = aligned[31:24];
      grp_nxt.bytes[1] = aligned[23:16];
      grp_nxt.bytes[2] = aligned[15:8];
      grp_nxt.last     = (bl3 == '0);
      buf_nxt = BUFFER_BITS'(acc3 & ~(32'hFFFF_FFFF << rem));
      bc_nxt  = BC_W'(rem);
      bl_nxt  = bl3;
    end
  end

  // Configuration decode: mode and length writes start a new message.
  always_comb begin
    v4 = cfg_data[NB_W-1:0];
    restart = cfg_we && (cfg_idx == REG_MODE || cfg_idx == REG_MSG_LEN);
    len_new = (cfg_idx == REG_MSG_LEN) ? cfg_data[ML-1:0] : msg_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_red_r   <= BITS_RESET;
      bits_green_r <= BITS_RESET;
      bits_blue_r  <= BITS_RESET;
      mode_r       <= MODE_EXTRACT;
      msg_len_r    <= '0;
      buf_r        <= '0;
      bc_r         <= '0;
      bh_r         <= '0;
      bl_r         <= '0;
      ovf_r        <= 1'b0;
    end else begin
      if (cfg_we && v4 <= BITS_MAX) begin
        case (cfg_idx)
          REG_BITS_RED:   bits_red_r   <= v4;
          REG_BITS_GREEN: bits_green_r <= v4;
          REG_BITS_BLUE:  bits_blue_r  <= v4;
          default: ;
        endcase
      end
      if (cfg_we && cfg_idx == REG_MODE) begin
        mode_r <= cfg_data[0];
      end
      if (restart) begin
        msg_len_r <= len_new;
        bl_r      <= {len_new, 3'b000};
        buf_r     <= '0;
        bc_r      <= '0;
        bh_r      <= '0;
        ovf_r     <= 1'b0;
      end else if (step) begin
        buf_r <= buf_nxt;
        bc_r  <= bc_nxt;
        bh_r  <= bh_nxt;
        bl_r  <= bl_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

// File: rtl/lsbse_emit.sv
module lsbse_emit
  import lsbse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  grp_t        grp_in,
  output logic        grp_take,
  lsbse_out_if.source out_if
);

  grp_t       grp_r;
  logic [1:0] cnt_r, idx_r;
  logic       pop, last_word;
  logic [7:0] byte_sel;

  assign pop       = out_if.valid && out_if.ready;
  assign last_word = (idx_r == cnt_r - 2'd1);
  assign grp_take  = (cnt_r == 2'd0) || (pop && last_word);

  // Pick the byte of the current word.
  always_comb begin
    case (idx_r)
      2'd0:    byte_sel = grp_r.bytes[0];
      2'd1:    byte_sel = grp_r.bytes[1];
      2'd2:    byte_sel = grp_r.bytes[2];
      default: byte_sel = 8'd0;
    endcase
  end

  // Result word seen on the output channel.
  always_comb begin
    out_if.valid          = (cnt_r != 2'd0);
    out_if.kind           = grp_r.kind;
    out_if.out_red        = grp_r.red;
    out_if.out_green      = grp_r.green;
    out_if.out_blue       = grp_r.blue;
    out_if.recovered_byte = byte_sel;
    out_if.last_byte      = grp_r.last && last_word;
    out_if.underflow      = grp_r.under;
    out_if.overflow       = grp_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

  // Word count and position within the held group.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= grp_in.cnt;
      idx_r <= 2'd0;
    end else if (pop) begin
      if (last_word) begin
        cnt_r <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

// File: rtl/lsb_stego_embed_extract.sv
// LSB steganography engine for an RGB pixel stream.
// Input channel (in_if): one word is either a message byte push (action 0)
// or a pixel (action 1). Configuration (cfg_*) selects the low bits per
// color, embed or extract mode and the message length in bytes; a write of
// mode or length starts a new message and clears the bit queue and the
// overflow flag. Configuration is to be written by the user only while the
// block is idle; the block itself does not enforce this. Output channel
// (out_if): in embed mode every pixel gives one pixel word; in extract mode
// a pixel gives zero to three recovered bytes, the final byte of the
// message marked by last_byte. Pushes give no word. Each input word passes
// the input register, then the result register. Throughput: one input word
// per cycle while each gives at most one result word and the receiver does
// not stall; an extract pixel with several bytes holds the result register
// until its last byte is taken, since the output channel moves one word per
// cycle. When the receiver stalls, the result register holds its word and
// the input register takes one more word before in_if.ready falls. Reset
// clears both registers' valid state, the message state and the
// configuration (two bits per color, extract mode, length zero).
module lsb_stego_embed_extract
  import lsbse_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int BUFFER_BITS = BUFFER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lsbse_in_if.sink              in_if,
  lsbse_out_if.source           out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t item_r;
  logic  item_v_r, item_v_nxt;
  logic  grp_take, step, accept;
  grp_t  grp_nxt;

  assign step        = item_v_r && grp_take;
  assign in_if.ready = !item_v_r || grp_take;
  assign accept      = in_if.valid && in_if.ready;

  // Input register.
  always_comb begin
    item_v_nxt = item_v_r;
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (step) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action       <= in_if.action;
      item_r.red          <= in_if.red;
      item_r.green        <= in_if.green;
      item_r.blue         <= in_if.blue;
      item_r.message_byte <= in_if.message_byte;
    end
  end

  lsbse_core #(
    .LENGTH_BITS (LENGTH_BITS),
    .BUFFER_BITS (BUFFER_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .step     (step),
    .item     (item_r),
    .grp_nxt  (grp_nxt)
  );

  lsbse_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step),
    .grp_in   (grp_nxt),
    .grp_take (grp_take),
    .out_if   (out_if)
  );

endmodule

// File: rtl/lsbse_chk.sv
module lsbse_chk
  import lsbse_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] recovered_byte,
  input logic       last_byte,
  input logic       underflow,
  input logic       overflow
);

  logic seen_ovf_r;

  // Remember a delivered overflow until the next configuration write.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      seen_ovf_r <= 1'b0;
    end else if (out_valid && out_ready && overflow) begin
      seen_ovf_r <= 1'b1;
    end
  end

  // A stalled word stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn while stalled");

  // A stalled word keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_kind, out_red, out_green, out_blue,
                                         recovered_byte, last_byte, underflow, overflow}))
    else $error("output word changed while stalled");

  // Pixel words carry no byte and no end-of-message mark.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PIXEL |-> recovered_byte == 8'd0 && !last_byte)
    else $error("pixel word carries byte fields");

  // Overflow stays set within a message once reported.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_ovf_r |-> overflow)
    else $error("overflow flag cleared within a message");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lsb_stego_embed_extract lsbse_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_we         (cfg_we),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_kind       (out_if.kind),
  .out_red        (out_if.out_red),
  .out_green      (out_if.out_green),
  .out_blue       (out_if.out_blue),
  .recovered_byte (out_if.recovered_byte),
  .last_byte      (out_if.last_byte),
  .underflow      (out_if.underflow),
  .overflow       (out_if.overflow)
);
